@@ rtl/core/h2r_pkg.sv @@
package h2r_pkg;

    localparam int HueW   = 11;
    localparam int ChanW  = 8;
    localparam int LevelW = 16;
    localparam int FracW  = 9;
    localparam int NumW   = 24;
    localparam int Stages = 5;
    localparam int Chans  = 3;

    localparam logic [HueW-1:0]  Turn      = 11'd1536;
    localparam logic [HueW-1:0]  Third     = 11'd512;
    localparam logic [HueW-1:0]  TwoThirds = 11'd1024;
    localparam logic [HueW-1:0]  Sixth     = 11'd256;
    localparam logic [HueW-1:0]  HalfTurn  = 11'd768;
    localparam logic [ChanW-1:0] HalfLit   = 8'd128;
    localparam logic [NumW-1:0]  RoundBias = 24'd32640;
    localparam logic [ChanW:0]   ChanMax   = 9'd255;

    localparam int ChRed   = 0;
    localparam int ChGreen = 1;
    localparam int ChBlue  = 2;

    // Weight of the high level along the piecewise hue ramp, in 256ths.
    function automatic logic [FracW-1:0] ramp_frac(input logic [HueW-1:0] t);
        logic [HueW-1:0] down;
        down = TwoThirds - t;
        if (t < Sixth) begin
            ramp_frac = FracW'(t);
        end else if (t < HalfTurn) begin
            ramp_frac = FracW'(Sixth);
        end else if (t < TwoThirds) begin
            ramp_frac = FracW'(down);
        end else begin
            ramp_frac = '0;
        end
    endfunction

endpackage

@@ rtl/core/h2r_if.sv @@
interface h2r_hsl_if;
    logic                         valid;
    logic                         ready;
    logic [h2r_pkg::HueW-1:0]     hue;
    logic [h2r_pkg::ChanW-1:0]    saturation;
    logic [h2r_pkg::ChanW-1:0]    lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

interface h2r_rgb_if;
    logic                         valid;
    logic                         ready;
    logic [h2r_pkg::ChanW-1:0]    red;
    logic [h2r_pkg::ChanW-1:0]    green;
    logic [h2r_pkg::ChanW-1:0]    blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/core/hsl_to_rgb_converter.sv @@
// An accepted request reaches o_rgb once it has passed through all five register stages.
// Throughput: one pixel per clock unless o_rgb stalls; each register stage moves on its own,
// so a stall at the output is absorbed by empty stages before it reaches i_hsl.ready.
// Reset: synchronous, active low; it clears only the stage valid bits, the data
// registers hold whatever they had and are never read while their valid bit is low.
module hsl_to_rgb_converter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    h2r_hsl_if.sink         i_hsl,
    h2r_rgb_if.source       o_rgb
);

    // Pipeline overview
    //   stage 1: fold the hue into one turn and form the two products l*(255+s) and l*s.
    //   stage 2: pick the high level, derive the low level and the span between them,
    //            and look up the ramp weight for the three channel hues.
    //   stage 3: one 16x9 multiply per channel: low*256 + span*weight + rounding bias.
    //   stage 4: divide by 65280 as a shift by eight and a reciprocal estimate of /255.
    //   stage 5: correct the estimate by one compare, clamp, and select grey for s == 0.
    // Every stage has a valid bit; a stage loads when it is empty or when the stage
    // after it loads, which forms a ready chain from the output back to the input.

    logic [h2r_pkg::Stages-1:0] r_vld;
    logic [h2r_pkg::Stages-1:0] w_en;

    always_comb begin
        w_en[h2r_pkg::Stages-1] = !r_vld[h2r_pkg::Stages-1] || o_rgb.ready;
        for (int i = h2r_pkg::Stages-2; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    assign i_hsl.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_hsl.valid;
            end
            for (int i = 1; i < h2r_pkg::Stages; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // Grey flag and lightness ride along so that zero saturation returns the
    // lightness exactly.
    logic [3:0]                  r_grey;
    logic [h2r_pkg::ChanW-1:0]   r_lit [4];

    // Stage 1: hue reduction and the two level products.
    logic [h2r_pkg::HueW-1:0]    n_s1_hue;
    logic [h2r_pkg::HueW-1:0]    r_s1_hue;
    logic [h2r_pkg::ChanW-1:0]   r_s1_sat;
    logic                        r_s1_dark;
    logic [16:0]                 n_s1_pa;
    logic [16:0]                 r_s1_pa;
    logic [15:0]                 n_s1_pb;
    logic [15:0]                 r_s1_pb;

    always_comb begin
        n_s1_hue = (i_hsl.hue >= h2r_pkg::Turn) ? i_hsl.hue - h2r_pkg::Turn : i_hsl.hue;
        n_s1_pa  = 17'(i_hsl.lightness) * 17'(9'd255 + 9'(i_hsl.saturation));
        n_s1_pb  = 16'(i_hsl.lightness) * 16'(i_hsl.saturation);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_hue  <= n_s1_hue;
            r_s1_sat  <= i_hsl.saturation;
            r_s1_dark <= i_hsl.lightness < h2r_pkg::HalfLit;
            r_s1_pa   <= n_s1_pa;
            r_s1_pb   <= n_s1_pb;
            r_grey[0] <= i_hsl.saturation == '0;
            r_lit[0]  <= i_hsl.lightness;
        end
    end

    // Stage 2: levels, span and ramp weights.
    logic [8:0]                  w_s2_sum;
    logic [16:0]                 w_s2_alt;
    logic [16:0]                 w_s2_high;
    logic [16:0]                 w_s2_low;
    logic [h2r_pkg::HueW-1:0]    w_s2_t [h2r_pkg::Chans];
    logic [h2r_pkg::LevelW-1:0]  r_s2_low;
    logic [h2r_pkg::LevelW-1:0]  r_s2_span;
    logic [h2r_pkg::FracW-1:0]   r_s2_frac [h2r_pkg::Chans];

    always_comb begin
        w_s2_sum  = 9'(r_lit[0]) + 9'(r_s1_sat);
        w_s2_alt  = (17'(w_s2_sum) << 8) - 17'(w_s2_sum) - 17'(r_s1_pb);
        w_s2_high = r_s1_dark ? r_s1_pa : w_s2_alt;
        w_s2_low  = (17'(r_lit[0]) << 9) - (17'(r_lit[0]) << 1) - w_s2_high;
        w_s2_t[h2r_pkg::ChRed]   = (r_s1_hue < h2r_pkg::TwoThirds)
                                   ? r_s1_hue + h2r_pkg::Third
                                   : r_s1_hue - h2r_pkg::TwoThirds;
        w_s2_t[h2r_pkg::ChGreen] = r_s1_hue;
        w_s2_t[h2r_pkg::ChBlue]  = (r_s1_hue < h2r_pkg::Third)
                                   ? r_s1_hue + h2r_pkg::TwoThirds
                                   : r_s1_hue - h2r_pkg::Third;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_low  <= w_s2_low[h2r_pkg::LevelW-1:0];
            r_s2_span <= w_s2_high[h2r_pkg::LevelW-1:0] - w_s2_low[h2r_pkg::LevelW-1:0];
            for (int c = 0; c < h2r_pkg::Chans; c++) begin
                r_s2_frac[c] <= h2r_pkg::ramp_frac(w_s2_t[c]);
            end
            r_grey[1] <= r_grey[0];
            r_lit[1]  <= r_lit[0];
        end
    end

    // Stage 3: ramp numerator with the rounding bias already added.
    logic [h2r_pkg::NumW-1:0]    r_s3_num [h2r_pkg::Chans];

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int c = 0; c < h2r_pkg::Chans; c++) begin
                r_s3_num[c] <= {r_s2_low, 8'b0}
                             + h2r_pkg::NumW'(r_s2_span) * h2r_pkg::NumW'(r_s2_frac[c])
                             + h2r_pkg::RoundBias;
            end
            r_grey[2] <= r_grey[1];
            r_lit[2]  <= r_lit[1];
        end
    end

    // Stage 4: y = num / 256, then q0 = floor(y * 257 / 65536), which is y / 255
    // or one below it for every 16-bit y.
    logic [15:0]                 r_s4_y  [h2r_pkg::Chans];
    logic [h2r_pkg::ChanW-1:0]   r_s4_q0 [h2r_pkg::Chans];
    logic [15:0]                 w_s4_y  [h2r_pkg::Chans];
    logic [24:0]                 w_s4_p  [h2r_pkg::Chans];

    always_comb begin
        for (int c = 0; c < h2r_pkg::Chans; c++) begin
            w_s4_y[c] = r_s3_num[c][23:8];
            w_s4_p[c] = {1'b0, w_s4_y[c], 8'b0} + 25'(w_s4_y[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int c = 0; c < h2r_pkg::Chans; c++) begin
                r_s4_y[c]  <= w_s4_y[c];
                r_s4_q0[c] <= w_s4_p[c][23:16];
            end
            r_grey[3] <= r_grey[2];
            r_lit[3]  <= r_lit[2];
        end
    end

    // Stage 5: one correction step, clamp and grey select into the output register.
    logic [16:0]                 w_s5_rem [h2r_pkg::Chans];
    logic [8:0]                  w_s5_q   [h2r_pkg::Chans];
    logic [h2r_pkg::ChanW-1:0]   w_s5_out [h2r_pkg::Chans];
    logic [h2r_pkg::ChanW-1:0]   r_out    [h2r_pkg::Chans];

    always_comb begin
        for (int c = 0; c < h2r_pkg::Chans; c++) begin
            w_s5_rem[c] = 17'(r_s4_y[c]) - (17'(r_s4_q0[c]) << 8) + 17'(r_s4_q0[c]);
            w_s5_q[c]   = 9'(r_s4_q0[c]) + 9'(w_s5_rem[c] >= 17'(h2r_pkg::ChanMax));
            if (r_grey[3]) begin
                w_s5_out[c] = r_lit[3];
            end else if (w_s5_q[c] > h2r_pkg::ChanMax) begin
                w_s5_out[c] = h2r_pkg::ChanMax[h2r_pkg::ChanW-1:0];
            end else begin
                w_s5_out[c] = w_s5_q[c][h2r_pkg::ChanW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int c = 0; c < h2r_pkg::Chans; c++) begin
                r_out[c] <= w_s5_out[c];
            end
        end
    end

    assign o_rgb.valid = r_vld[h2r_pkg::Stages-1];
    assign o_rgb.red   = r_out[h2r_pkg::ChRed];
    assign o_rgb.green = r_out[h2r_pkg::ChGreen];
    assign o_rgb.blue  = r_out[h2r_pkg::ChBlue];

`ifndef SYNTHESIS
    // The two levels never leave the 0..65025 range.
    a_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (17'(r_s2_low) + 17'(r_s2_span) <= 17'd65025))
        else $error("level span exceeds full scale");

    // Ramp weights stay within one sixth of a turn.
    a_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_s2_frac[0] <= 9'd256 && r_s2_frac[1] <= 9'd256
                      && r_s2_frac[2] <= 9'd256))
        else $error("ramp weight out of range");

    // The reciprocal estimate never overshoots, so one upward correction suffices.
    a_quot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] |-> (17'(r_s4_q0[0]) * 17'd255 <= 17'(r_s4_y[0])
                      && 17'(r_s4_q0[1]) * 17'd255 <= 17'(r_s4_y[1])
                      && 17'(r_s4_q0[2]) * 17'd255 <= 17'(r_s4_y[2])))
        else $error("quotient estimate too large");

    // While the output is stalled, the input is ready exactly when some stage is empty.
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rgb.valid && !o_rgb.ready) |-> (i_hsl.ready == !(&r_vld)))
        else $error("ready chain does not match pipeline occupancy");
`endif

endmodule
